// ===== rtl/sha1sh_pkg.sv =====
// Shared types and constants of the SHA-1 stream hasher.
// Used by sha1sh_sched, sha1sh_round and sha1_stream_hasher_unit; no dependencies.

package sha1sh_pkg;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam int BLOCK_BYTES   = 64;
	localparam int LEN_FIELD_BIT = 448;
	localparam int ROUNDS        = 80;
	localparam int DIGEST_WORDS  = 5;

	localparam logic [5:0] POS_LAST  = 6'(BLOCK_BYTES - 1);
	localparam logic [5:0] POS_LEN   = 6'(LEN_FIELD_BIT / 8);
	localparam logic [6:0] RND_LAST  = 7'(ROUNDS - 1);
	localparam logic [2:0] WORD_LAST = 3'(DIGEST_WORDS - 1);

	typedef struct packed {
		logic       byte_en;
		logic [7:0] byte_val;
		logic       word_en;
	} sched_ctl_t;

	function automatic logic [31:0] h_init(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0:    v = 32'h67452301;
			3'd1:    v = 32'hEFCDAB89;
			3'd2:    v = 32'h98BADCFE;
			3'd3:    v = 32'h10325476;
			default: v = 32'hC3D2E1F0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/sha1_stream_hasher_unit.sv =====
// Top level of the SHA-1 stream hasher: sequencer, chaining value, working registers.
// Depends on sha1sh_pkg, sha1sh_sched, sha1sh_round.
//
//  channel | signals                                  | beat
//  item    | item_valid item_ready kind data_byte     | one message byte or finish
//  res     | res_valid res_ready digest_word          | one digest word, H0 first
//          |   word_index last_word                   |
//
// A data byte is accepted in ST_IDLE; the byte that fills a block starts the round states and
// then the fold states. Finish pads one byte a cycle to the block end, then compresses;
// a marker past byte 55 costs a further padded block and a further compression.
// Five beats on res follow.
// item_ready is low from a full block or finish until the compression or digest is done.
// Reset reloads the initial chaining value and clears the bit count.

module sha1_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FOLD  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]  state_q;
	logic [31:0] h_q [5];
	logic [63:0] bit_len_q;
	logic [5:0]  pos_q;
	logic        fin_q;
	logic        mark_q;
	logic        zfill_q;
	logic [6:0]  rnd_q;
	logic [2:0]  fold_q;
	logic [2:0]  oidx_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	logic                   data_take;
	logic                   blk_end;
	logic [63:0]            len_sh;
	logic [7:0]             pad_byte;
	logic [31:0]            w_cur;
	logic [31:0]            t_rnd;
	logic [31:0]            fold_sum;
	sha1sh_pkg::sched_ctl_t sched_ctl;

	assign item_ready = (state_q == ST_IDLE);
	assign data_take  = item_valid && item_ready && (kind == sha1sh_pkg::KIND_DATA);
	assign blk_end    = (data_take || state_q == ST_PAD) && (pos_q == sha1sh_pkg::POS_LAST);

	// length bytes go big-endian into positions 56..63
	assign len_sh = bit_len_q >> {~pos_q[2:0], 3'b000};

	always_comb begin
		if (mark_q) begin
			pad_byte = 8'h80;
		end else if (pos_q >= sha1sh_pkg::POS_LEN && !zfill_q) begin
			pad_byte = len_sh[7:0];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign sched_ctl.byte_en  = data_take || (state_q == ST_PAD);
	assign sched_ctl.byte_val = (state_q == ST_PAD) ? pad_byte : data_byte;
	assign sched_ctl.word_en  = (state_q == ST_ROUND);

	sha1sh_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.w_cur (w_cur)
	);

	sha1sh_round u_round (
		.rnd (rnd_q),
		.a   (a_q),
		.b   (b_q),
		.c   (c_q),
		.d   (d_q),
		.e   (e_q),
		.w   (w_cur),
		.t   (t_rnd)
	);

	assign fold_sum = h_q[0] + a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
				h_q[i] <= sha1sh_pkg::h_init(3'(i));
			end
			bit_len_q <= '0;
			pos_q     <= '0;
			fin_q     <= 1'b0;
			mark_q    <= 1'b0;
			zfill_q   <= 1'b0;
			rnd_q     <= '0;
			fold_q    <= '0;
			oidx_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (kind == sha1sh_pkg::KIND_DATA) begin
							bit_len_q <= bit_len_q + 64'd8;
							pos_q     <= pos_q + 6'd1;
							if (blk_end) begin
								state_q <= ST_ROUND;
								rnd_q   <= '0;
							end
						end else begin
							fin_q   <= 1'b1;
							mark_q  <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b0;
					// marker too late for the length field: zero-fill and compress first
					if (mark_q && pos_q >= sha1sh_pkg::POS_LEN) begin
						zfill_q <= 1'b1;
					end
					pos_q <= pos_q + 6'd1;
					if (blk_end) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == sha1sh_pkg::RND_LAST) begin
						state_q <= ST_FOLD;
						fold_q  <= '0;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS - 1; i++) begin
						h_q[i] <= h_q[i + 1];
					end
					h_q[4] <= fold_sum;
					fold_q <= fold_q + 3'd1;
					if (fold_q == sha1sh_pkg::WORD_LAST) begin
						if (!fin_q) begin
							state_q <= ST_IDLE;
						end else if (zfill_q) begin
							zfill_q <= 1'b0;
							state_q <= ST_PAD;
						end else begin
							oidx_q  <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS - 1; i++) begin
							h_q[i] <= h_q[i + 1];
						end
						h_q[4] <= sha1sh_pkg::h_init(oidx_q);
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == sha1sh_pkg::WORD_LAST) begin
							state_q   <= ST_IDLE;
							fin_q     <= 1'b0;
							bit_len_q <= '0;
							pos_q     <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working variables: loaded at block end, one round a cycle, shifted during fold
	always_ff @(posedge clk) begin
		if (blk_end) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t_rnd;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end else if (state_q == ST_FOLD) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= e_q;
		end
	end

	assign res_valid   = (state_q == ST_OUT);
	assign digest_word = h_q[0];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == sha1sh_pkg::WORD_LAST);

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !item_ready)
		else $error("item_ready high while digest beats pending");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (word_index <= sha1sh_pkg::WORD_LAST))
		else $error("word_index out of range");

	a_last_free: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && last_word) |=> (item_ready && bit_len_q == 64'd0))
		else $error("not idle and cleared after last digest beat");

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= sha1sh_pkg::RND_LAST))
		else $error("round counter overran");

	a_pad_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD) |-> fin_q)
		else $error("padding without finish");

endmodule

// ===== rtl/sha1sh_sched.sv =====
// Block buffer and message schedule window: bytes shift in, rounds shift words out.
// Depends on sha1sh_pkg.

module sha1sh_sched (
	input  logic                   clk,
	input  sha1sh_pkg::sched_ctl_t ctl,
	output logic [31:0]            w_cur
);

	logic [511:0] win_q;
	logic [31:0]  w_mix;
	logic [31:0]  w_next;

	assign w_cur  = win_q[511:480];
	assign w_mix  = win_q[95:64] ^ win_q[255:224] ^ win_q[447:416] ^ w_cur;
	assign w_next = {w_mix[30:0], w_mix[31]};

	always_ff @(posedge clk) begin
		if (ctl.word_en) begin
			win_q <= {win_q[479:0], w_next};
		end else if (ctl.byte_en) begin
			win_q <= {win_q[503:0], ctl.byte_val};
		end
	end

endmodule

// ===== rtl/sha1sh_round.sv =====
// One SHA-1 round: boolean function, round constant and the five-way sum.
// Depends on sha1sh_pkg.

module sha1sh_round (
	input  logic [6:0]  rnd,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] e,
	input  logic [31:0] w,
	output logic [31:0] t
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd inside {[7'd0:7'd19]}) begin
			f = (b & c) | (~b & d);
			k = sha1sh_pkg::K_R0;
		end else if (rnd inside {[7'd20:7'd39]}) begin
			f = b ^ c ^ d;
			k = sha1sh_pkg::K_R1;
		end else if (rnd inside {[7'd40:7'd59]}) begin
			f = (b & c) | (b & d) | (c & d);
			k = sha1sh_pkg::K_R2;
		end else begin
			f = b ^ c ^ d;
			k = sha1sh_pkg::K_R3;
		end
	end

	assign t = {a[26:0], a[31:27]} + f + e + k + w;

endmodule
